/* rtl/core/gamepad_event_queue_autorepeat_defines.svh */
// Assertion macros shared by the gamepad event queue RTL.
`ifndef GAMEPAD_EVENT_QUEUE_AUTOREPEAT_DEFINES_SVH
`define GAMEPAD_EVENT_QUEUE_AUTOREPEAT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define GEQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gamepad event queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define GEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gamepad event queue check failed");

`else

`define GEQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/geq_pkg.sv */
// Shared constants, codes and types of the gamepad event queue.
`default_nettype none

package geq_pkg;

	localparam int CONTROLLERS = 4;
	localparam int QUEUE_DEPTH = 8;

	localparam int CIDX_W  = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
	localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
	localparam int EADDR_W = CIDX_W + SLOT_W;
	localparam int EDEPTH  = 1 << EADDR_W;
	localparam int SADDR_W = 1 + CIDX_W;
	localparam int SDEPTH  = 1 << SADDR_W;
	localparam int PAY_W   = 32;
	localparam int ENTRY_W = 2 + PAY_W;
	localparam int STICK_W = 64;

	localparam logic [15:0] THRESH_RST   = 16'd29490;
	localparam logic [15:0] INTERVAL_RST = 16'd250;
	localparam logic [15:0] AXIS_MAX     = 16'h7FFF;
	localparam logic [15:0] AXIS_MIN     = 16'h8000;

	typedef enum logic [1:0] {
		OP_QUEUE = 2'd0,
		OP_GET   = 2'd1,
		OP_FLUSH = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NULL   = 2'd0,
		EV_LSTICK = 2'd1,
		EV_RSTICK = 2'd2,
		EV_BUTTON = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		REG_SUPPRESSED = 2'd0,
		REG_THRESHOLD  = 2'd1,
		REG_INTERVAL   = 2'd2
	} reg_idx_t;

	// One queue entry: type code and packed payload (stick axes or button data).
	typedef struct packed {
		logic [1:0]       etype;
		logic [PAY_W-1:0] pay;
	} entry_t;

	// Write-back commands from the top level to the queue store.
	typedef struct packed {
		logic              push;
		logic              pop;
		logic              clear;
		logic [CIDX_W-1:0] push_c;
		entry_t            push_e;
	} q_cmd_t;

	// Outcome of a get lookup.
	typedef struct packed {
		logic              found;
		logic [CIDX_W-1:0] c;
		entry_t            e;
	} q_res_t;

	// Stick decision and the axes that go to the queue and back to the store.
	typedef struct packed {
		logic        post;
		logic [15:0] x;
		logic [15:0] y;
	} stick_res_t;

	// Magnitude of a two's complement axis, 17 bits so full negative scale fits.
	function automatic logic [16:0] mag17(input logic [15:0] v);
		logic [16:0] m;
		if (v[15]) begin
			m = {1'b0, ~v} + 17'd1;
		end else begin
			m = {1'b0, v};
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/gamepad_event_queue_autorepeat.sv */
// Top level of the gamepad event queue with stick autorepeat.
//
// Usage: drive operation and its fields and raise start while busy is low;
// the item is taken at that clock edge. Operations are queue, get, flush and
// initialize. busy stays high for the cycle after acceptance, while the
// event RAM and the stick history RAM return their read data and the
// read-modify-write completes. Exactly one result follows every item: done
// is registered from busy and stays high for one cycle with valid_res, the
// event fields and last_event_time. A new item can be taken in the cycle
// that done is high, but not before the last item has completed its
// read-modify-write, since the RAMs have registered read data.
// Configuration (suppressed, stick threshold, repeat interval) is written
// through cfg_we, cfg_idx and cfg_wdata in any idle cycle.
// Reset clears every queue, the stick history, the last event time and
// suppression, and loads the default threshold and interval; no clearing
// pass is needed. The receiver cannot stall: results are not held.
`default_nettype none

`include "gamepad_event_queue_autorepeat_defines.svh"

module gamepad_event_queue_autorepeat (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic [1:0]         operation,
	input  wire logic [1:0]         controller,
	input  wire logic               any_controller,
	input  wire logic [1:0]         event_type,
	input  wire logic signed [15:0] stick_x,
	input  wire logic signed [15:0] stick_y,
	input  wire logic [7:0]         button_id,
	input  wire logic [7:0]         button_value,
	input  wire logic [31:0]        time_ms,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [15:0]        cfg_wdata,
	output      logic               done,
	output      logic               valid_res,
	output      logic [1:0]         out_type,
	output      logic [1:0]         out_controller,
	output      logic signed [15:0] out_x,
	output      logic signed [15:0] out_y,
	output      logic [7:0]         out_button,
	output      logic [7:0]         out_value,
	output      logic [31:0]        last_event_time
);

	import geq_pkg::*;

	logic        accept;
	logic        vld_s1;
	op_t         op_s1;
	logic [1:0]  ctrl_s1;
	ev_t         type_s1;
	logic [15:0] x_s1;
	logic [15:0] y_s1;
	logic [7:0]  btn_s1;
	logic [7:0]  val_s1;
	logic [31:0] time_s1;

	logic        supp_q;
	logic [15:0] thr_q;
	logic [15:0] intv_q;
	logic [31:0] last_time_q;

	logic        ctrl_ok_s1;
	logic        is_stick;
	logic        do_queue;
	logic        post;
	logic        stick_upd;
	q_cmd_t      qcmd;
	q_res_t      qres;
	stick_res_t  sres;
	entry_t      push_e;

	logic        res_valid;
	logic [1:0]  res_type;
	logic [1:0]  res_c;
	logic [15:0] res_x;
	logic [15:0] res_y;
	logic [7:0]  res_btn;
	logic [7:0]  res_val;

	logic        done_q;
	logic        valid_q;
	logic [1:0]  type_q;
	logic [1:0]  c_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [7:0]  btn_q;
	logic [7:0]  val_q;

	assign accept = start && !vld_s1;
	assign busy   = vld_s1;

	// Item capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(operation);
			ctrl_s1 <= controller;
			type_s1 <= ev_t'(event_type);
			x_s1    <= stick_x;
			y_s1    <= stick_y;
			btn_s1  <= button_id;
			val_s1  <= button_value;
			time_s1 <= time_ms;
		end
	end

	// Post decision for a queue item.
	assign ctrl_ok_s1 = int'(ctrl_s1) < CONTROLLERS;
	assign is_stick   = (type_s1 == EV_LSTICK) || (type_s1 == EV_RSTICK);
	assign do_queue   = (op_s1 == OP_QUEUE) && !supp_q && ctrl_ok_s1;
	assign post       = do_queue && (is_stick ? sres.post : 1'b1);
	assign stick_upd  = vld_s1 && do_queue && is_stick;

	// Entry payload packing.
	always_comb begin
		push_e.etype = type_s1;
		push_e.pay   = '0;
		if (is_stick) begin
			push_e.pay = {sres.x, sres.y};
		end else if (type_s1 == EV_BUTTON) begin
			push_e.pay = {16'd0, btn_s1, val_s1};
		end
	end

	assign qcmd.push   = vld_s1 && post;
	assign qcmd.pop    = vld_s1 && (op_s1 == OP_GET) && qres.found;
	assign qcmd.clear  = vld_s1 && ((op_s1 == OP_FLUSH) || (op_s1 == OP_INIT));
	assign qcmd.push_c = CIDX_W'(ctrl_s1);
	assign qcmd.push_e = push_e;

	geq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (accept),
		.rd_any (any_controller),
		.rd_ctrl(controller),
		.cmd    (qcmd),
		.res    (qres)
	);

	geq_stick u_stick (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (accept),
		.rd_type(event_type),
		.rd_ctrl(controller),
		.upd    (stick_upd),
		.x      (x_s1),
		.y      (y_s1),
		.now    (time_s1),
		.thr    (thr_q),
		.intv   (intv_q),
		.res    (sres)
	);

	// Configuration registers, last event time and suppression.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supp_q      <= 1'b0;
			thr_q       <= THRESH_RST;
			intv_q      <= INTERVAL_RST;
			last_time_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SUPPRESSED: supp_q <= cfg_wdata[0];
					REG_THRESHOLD:  thr_q  <= cfg_wdata;
					REG_INTERVAL:   intv_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (vld_s1 && (op_s1 == OP_INIT)) begin
				supp_q      <= 1'b0;
				last_time_q <= time_s1;
			end else if (vld_s1 && post && (type_s1 != EV_NULL)) begin
				last_time_q <= time_s1;
			end
		end
	end

	// Result fields; everything but the last event time is zero without a result.
	always_comb begin
		res_valid = 1'b0;
		res_type  = '0;
		res_c     = '0;
		res_x     = '0;
		res_y     = '0;
		res_btn   = '0;
		res_val   = '0;
		unique case (op_s1)
			OP_QUEUE: begin
				if (post) begin
					res_valid = 1'b1;
					res_type  = type_s1;
					res_c     = ctrl_s1;
					if (is_stick) begin
						res_x = sres.x;
						res_y = sres.y;
					end else if (type_s1 == EV_BUTTON) begin
						res_btn = btn_s1;
						res_val = val_s1;
					end
				end
			end
			OP_GET: begin
				if (qres.found) begin
					res_valid = 1'b1;
					res_type  = qres.e.etype;
					res_c     = 2'(qres.c);
					if ((qres.e.etype == EV_LSTICK) || (qres.e.etype == EV_RSTICK)) begin
						res_x = qres.e.pay[31:16];
						res_y = qres.e.pay[15:0];
					end else if (qres.e.etype == EV_BUTTON) begin
						res_btn = qres.e.pay[15:8];
						res_val = qres.e.pay[7:0];
					end
				end
			end
			OP_FLUSH, OP_INIT: ;
		endcase
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			valid_q <= res_valid;
			type_q  <= res_type;
			c_q     <= res_c;
			x_q     <= res_x;
			y_q     <= res_y;
			btn_q   <= res_btn;
			val_q   <= res_val;
		end
	end

	assign done            = done_q;
	assign valid_res       = valid_q;
	assign out_type        = type_q;
	assign out_controller  = c_q;
	assign out_x           = x_q;
	assign out_y           = y_q;
	assign out_button      = btn_q;
	assign out_value       = val_q;
	assign last_event_time = last_time_q;

	// Every result belongs to an accepted item, carried through vld_s1 and done_q.
	`GEQ_ASSERT_IMPLY(a_done_follows_accept, clk, arst_n, done, $past(accept, 2))
	// The block is free again while a result is shown.
	`GEQ_ASSERT_IMPLY(a_done_not_busy, clk, arst_n, done, !busy)

endmodule

`default_nettype wire

/* rtl/core/geq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module geq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/geq_stick.sv */
// Stick history store and the post-or-drop decision for stick events.
`default_nettype none

module geq_stick (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd,
	input  wire logic [1:0]          rd_type,
	input  wire logic [1:0]          rd_ctrl,
	input  wire logic                upd,
	input  wire logic [15:0]         x,
	input  wire logic [15:0]         y,
	input  wire logic [31:0]         now,
	input  wire logic [15:0]         thr,
	input  wire logic [15:0]         intv,
	output      geq_pkg::stick_res_t res
);

	import geq_pkg::*;

	logic [SADDR_W-1:0] rd_addr;
	logic [SADDR_W-1:0] addr_s1;
	logic [SDEPTH-1:0]  seen_q;
	logic [STICK_W-1:0] rdata;
	logic [STICK_W-1:0] old;
	logic [STICK_W-1:0] wdata;
	logic [15:0]        px;
	logic [15:0]        py;
	logic [31:0]        ptime;
	logic [31:0]        elapsed;
	logic               xd;
	logic               yd;
	logic               pxd;
	logic               pyd;

	// One entry per stick and controller: right sticks live in the upper half.
	assign rd_addr = {(rd_type == EV_RSTICK), CIDX_W'(rd_ctrl)};

	always_ff @(posedge clk) begin
		if (rd) begin
			addr_s1 <= rd_addr;
		end
	end

	// Entries never written read as zero history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (upd) begin
			seen_q[addr_s1] <= 1'b1;
		end
	end

	assign old   = seen_q[addr_s1] ? rdata : '0;
	assign px    = old[63:48];
	assign py    = old[47:32];
	assign ptime = old[31:0];

	// Threshold crossings against the current and the previous axes.
	assign xd      = mag17(x) >= {1'b0, thr};
	assign yd      = mag17(y) >= {1'b0, thr};
	assign pxd     = mag17(px) >= {1'b0, thr};
	assign pyd     = mag17(py) >= {1'b0, thr};
	assign elapsed = now - ptime;

	// Post on a fresh crossing or once the repeat interval has run out; posted axes past the threshold saturate.
	always_comb begin
		res.post = (xd || yd) &&
			((xd && !pxd) || (yd && !pyd) || (elapsed >= {16'd0, intv}));
		res.x = x;
		res.y = y;
		if (res.post && xd) begin
			res.x = x[15] ? AXIS_MIN : AXIS_MAX;
		end
		if (res.post && yd) begin
			res.y = y[15] ? AXIS_MIN : AXIS_MAX;
		end
	end

	assign wdata = {res.x, res.y, (res.post ? now : ptime)};

	geq_ram #(
		.WIDTH(STICK_W),
		.DEPTH(SDEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (upd),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (rd),
		.raddr(rd_addr),
		.rdata(rdata)
	);

endmodule

`default_nettype wire

/* rtl/core/geq_queue.sv */
// Per-controller event rings in one RAM, with live flags and the get search.
`default_nettype none

`include "gamepad_event_queue_autorepeat_defines.svh"

module geq_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd,
	input  wire logic            rd_any,
	input  wire logic [1:0]      rd_ctrl,
	input  wire geq_pkg::q_cmd_t cmd,
	output      geq_pkg::q_res_t res
);

	import geq_pkg::*;

	logic [CONTROLLERS-1:0][QUEUE_DEPTH-1:0] live_q;
	logic [CONTROLLERS-1:0][SLOT_W-1:0]      head_q;
	logic [CONTROLLERS-1:0]                  has;
	logic [CONTROLLERS-1:0][SLOT_W-1:0]      oldest;
	logic                                    sel_found;
	logic [CIDX_W-1:0]                       sel_c;
	logic [SLOT_W-1:0]                       sel_slot;
	logic                                    rd_ctrl_ok;
	logic                                    get_found_s1;
	logic [CIDX_W-1:0]                       get_c_s1;
	logic [SLOT_W-1:0]                       get_slot_s1;
	logic [SLOT_W-1:0]                       head_dec;
	logic [ENTRY_W-1:0]                      rdata;

	// Physical slot of a logical position, wrapping at the queue depth.
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
			input int ofs);
		logic [SLOT_W:0] sum;
		sum = {1'b0, base} + (SLOT_W+1)'(ofs);
		if (sum >= (SLOT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (SLOT_W+1)'(QUEUE_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

	// Oldest live entry of every ring: the highest logical position wins.
	always_comb begin
		has    = '0;
		oldest = '0;
		for (int k = 0; k < CONTROLLERS; k++) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (live_q[k][slot_add(head_q[k], i)]) begin
					has[k]    = 1'b1;
					oldest[k] = slot_add(head_q[k], i);
				end
			end
		end
	end

	assign rd_ctrl_ok = int'(rd_ctrl) < CONTROLLERS;

	// Pick the ring to serve: the lowest non-empty one, or the one asked for.
	always_comb begin
		sel_found = 1'b0;
		sel_c     = '0;
		sel_slot  = '0;
		if (rd_any) begin
			for (int k = CONTROLLERS - 1; k >= 0; k--) begin
				if (has[k]) begin
					sel_found = 1'b1;
					sel_c     = CIDX_W'(k);
					sel_slot  = oldest[k];
				end
			end
		end else if (rd_ctrl_ok) begin
			sel_c     = CIDX_W'(rd_ctrl);
			sel_found = has[sel_c];
			sel_slot  = oldest[sel_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			get_found_s1 <= 1'b0;
		end else if (rd) begin
			get_found_s1 <= sel_found;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			get_c_s1    <= sel_c;
			get_slot_s1 <= sel_slot;
		end
	end

	// A push moves the head back one slot, over the oldest entry when the ring is full.
	assign head_dec = (head_q[cmd.push_c] == '0) ? SLOT_W'(QUEUE_DEPTH - 1)
		: head_q[cmd.push_c] - SLOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			head_q <= '0;
		end else begin
			if (cmd.clear) begin
				live_q <= '0;
			end else if (cmd.push) begin
				head_q[cmd.push_c]           <= head_dec;
				live_q[cmd.push_c][head_dec] <= (cmd.push_e.etype != EV_NULL);
			end else if (cmd.pop) begin
				live_q[get_c_s1][get_slot_s1] <= 1'b0;
			end
		end
	end

	geq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(EDEPTH)
	) u_event_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr({cmd.push_c, head_dec}),
		.wdata(cmd.push_e),
		.re   (rd),
		.raddr({sel_c, sel_slot}),
		.rdata(rdata)
	);

	assign res.found = get_found_s1;
	assign res.c     = get_c_s1;
	assign res.e     = rdata;

	// A get only ever clears an entry that is live.
	`GEQ_ASSERT_IMPLY(a_pop_live, clk, arst_n, cmd.pop, live_q[get_c_s1][get_slot_s1])
	// Flush and initialize leave every ring empty.
	`GEQ_ASSERT_NEXT(a_clear_empties, clk, arst_n, cmd.clear, live_q == '0)

endmodule

`default_nettype wire

/* bench/gamepad_event_queue_autorepeat_tb.sv */
// Self-checking testbench for the gamepad event queue with stick autorepeat.
`timescale 1ns / 100ps

module gamepad_event_queue_autorepeat_tb;

	import geq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// One command item as driven onto the block's ports.
	typedef struct packed {
		op_t                op;
		logic [1:0]         ctrl;
		logic               any;
		ev_t                etype;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [7:0]         btn;
		logic [7:0]         val;
		logic [31:0]        now;
	} pad_cmd_t;

	// One result as seen on the result ports while done is high.
	typedef struct packed {
		logic        valid;
		logic [1:0]  etype;
		logic [1:0]  ctrl;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  btn;
		logic [7:0]  val;
		logic [31:0] let_ms;
	} pad_res_t;

	// One slot of a controller's event queue.
	typedef struct packed {
		ev_t                etype;
		logic [1:0]         ctrl;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         btn;
		logic [7:0]         val;
	} slot_t;

	// A stimulus row; pinned rows carry a result that is known by inspection.
	typedef struct packed {
		pad_cmd_t cmd;
		logic     pinned;
		pad_res_t res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [1:0]         controller;
	logic               any_controller;
	logic [1:0]         event_type;
	logic signed [15:0] stick_x;
	logic signed [15:0] stick_y;
	logic [7:0]         button_id;
	logic [7:0]         button_value;
	logic [31:0]        time_ms;
	logic               cfg_we;
	logic [1:0]         cfg_idx;
	logic [15:0]        cfg_wdata;
	logic               done;
	logic               valid_res;
	logic [1:0]         out_type;
	logic [1:0]         out_controller;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [7:0]         out_button;
	logic [7:0]         out_value;
	logic [31:0]        last_event_time;

	// Shadow of the block's queues, stick history and configuration.
	slot_t              queue_mem [CONTROLLERS][QUEUE_DEPTH];
	logic signed [15:0] prev_x [2][CONTROLLERS];
	logic signed [15:0] prev_y [2][CONTROLLERS];
	logic [31:0]        stick_post_ms [2][CONTROLLERS];
	logic [31:0]        last_post_ms;
	logic               cfg_suppressed;
	int                 cfg_threshold;
	int                 cfg_interval;

	pad_res_t  pending_results[$];
	stim_row_t directed_rows[$];
	int        mismatch_count;
	int        cycle_count;

	// Stimulus state: running millisecond clock and held stick positions.
	logic [31:0]        clock_ms;
	logic signed [15:0] held_x [2][4];
	logic signed [15:0] held_y [2][4];

	gamepad_event_queue_autorepeat i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.controller      (controller),
		.any_controller  (any_controller),
		.event_type      (event_type),
		.stick_x         (stick_x),
		.stick_y         (stick_y),
		.button_id       (button_id),
		.button_value    (button_value),
		.time_ms         (time_ms),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.valid_res       (valid_res),
		.out_type        (out_type),
		.out_controller  (out_controller),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_button      (out_button),
		.out_value       (out_value),
		.last_event_time (last_event_time)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Absolute value of an axis; full negative scale gives 32768.
	function automatic int axis_abs(input logic signed [15:0] v);
		int a;
		a = v;
		return (a < 0) ? -a : a;
	endfunction

	// Removes the oldest non-null entry of one controller's queue.
	function automatic logic take_oldest(input int c, output slot_t e);
		logic hit;
		int   i;
		hit = 1'b0;
		e = '0;
		for (i = QUEUE_DEPTH - 1; i >= 0 && !hit; i--) begin
			if (queue_mem[c][i].etype != EV_NULL) begin
				e = queue_mem[c][i];
				queue_mem[c][i].etype = EV_NULL;
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Applies one command to the shadow state and returns the result it causes.
	function automatic pad_res_t predict_pad_result(input pad_cmd_t c);
		pad_res_t           r;
		slot_t              e;
		logic               found;
		logic               xd;
		logic               yd;
		logic [31:0]        elapsed;
		logic signed [15:0] x;
		logic signed [15:0] y;
		int                 s;
		int                 i;
		int                 k;
		r = '0;
		e = '0;
		found = 1'b0;
		case (c.op)
			OP_QUEUE: begin
				if (!cfg_suppressed && c.ctrl < CONTROLLERS) begin
					found = 1'b1;
					e.etype = c.etype;
					e.ctrl = c.ctrl;
					if (c.etype == EV_LSTICK || c.etype == EV_RSTICK) begin
						s = (c.etype == EV_LSTICK) ? 0 : 1;
						x = c.sx;
						y = c.sy;
						xd = axis_abs(x) >= cfg_threshold;
						yd = axis_abs(y) >= cfg_threshold;
						elapsed = c.now - stick_post_ms[s][c.ctrl];
						if (!xd && !yd) begin
							found = 1'b0;
						end else if (!((xd && axis_abs(prev_x[s][c.ctrl]) < cfg_threshold) ||
							(yd && axis_abs(prev_y[s][c.ctrl]) < cfg_threshold) ||
							elapsed >= cfg_interval)) begin
							found = 1'b0;
						end else begin
							stick_post_ms[s][c.ctrl] = c.now;
							if (xd) begin
								x = x[15] ? 16'sh8000 : 16'sh7FFF;
							end
							if (yd) begin
								y = y[15] ? 16'sh8000 : 16'sh7FFF;
							end
						end
						// History takes the raw axes, or the saturated ones when posted.
						prev_x[s][c.ctrl] = x;
						prev_y[s][c.ctrl] = y;
						e.x = x;
						e.y = y;
					end else if (c.etype == EV_BUTTON) begin
						e.btn = c.btn;
						e.val = c.val;
					end
					if (found) begin
						for (i = QUEUE_DEPTH - 1; i > 0; i--) begin
							queue_mem[c.ctrl][i] = queue_mem[c.ctrl][i - 1];
						end
						queue_mem[c.ctrl][0] = e;
						if (c.etype != EV_NULL) begin
							last_post_ms = c.now;
						end
					end
				end
			end
			OP_GET: begin
				if (c.any) begin
					for (k = 0; k < CONTROLLERS && !found; k++) begin
						found = take_oldest(k, e);
					end
				end else if (c.ctrl < CONTROLLERS) begin
					found = take_oldest(c.ctrl, e);
				end
			end
			default: begin
				// Flush and initialize both empty every queue.
				for (k = 0; k < CONTROLLERS; k++) begin
					for (i = 0; i < QUEUE_DEPTH; i++) begin
						queue_mem[k][i] = '0;
					end
				end
				if (c.op == OP_INIT) begin
					last_post_ms = c.now;
					cfg_suppressed = 1'b0;
				end
			end
		endcase
		if (found) begin
			r.valid = 1'b1;
			r.etype = e.etype;
			r.ctrl = e.ctrl;
			r.x = e.x;
			r.y = e.y;
			r.btn = e.btn;
			r.val = e.val;
		end
		r.let_ms = last_post_ms;
		return r;
	endfunction

	// Appends a directed row whose result comes from the predictor.
	function automatic void add_row(input op_t op, input logic [1:0] ctrl, input logic any,
		input ev_t et, input int sx, input int sy, input int btn, input int val,
		input logic [31:0] now);
		stim_row_t row;
		row = '0;
		row.cmd.op = op;
		row.cmd.ctrl = ctrl;
		row.cmd.any = any;
		row.cmd.etype = et;
		row.cmd.sx = sx[15:0];
		row.cmd.sy = sy[15:0];
		row.cmd.btn = btn[7:0];
		row.cmd.val = val[7:0];
		row.cmd.now = now;
		directed_rows.push_back(row);
	endfunction

	// Pins the result of the last directed row; only non-stick results are pinned.
	function automatic void pin_result(input logic v, input ev_t et, input logic [1:0] ctrl,
		input logic [7:0] btn, input logic [7:0] val, input logic [31:0] let_ms);
		int n;
		n = directed_rows.size() - 1;
		directed_rows[n].pinned = 1'b1;
		directed_rows[n].res = {v, et, ctrl, 16'd0, 16'd0, btn, val, let_ms};
	endfunction

	// Axis value from a mix of rest, threshold edge, extremes and full range.
	function automatic logic signed [15:0] pick_axis();
		int r;
		int m;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			m = $urandom_range(0, 4000) - 2000;
		end else if (r < 6) begin
			m = cfg_threshold + $urandom_range(0, 6) - 3;
			if (m < 0) m = 0;
			if ($urandom_range(0, 1)) begin
				m = -m;
				if (m < -32768) m = -32768;
			end else if (m > 32767) begin
				m = 32767;
			end
		end else if (r == 6) begin
			case ($urandom_range(0, 3))
				0: m = 32767;
				1: m = -32768;
				2: m = 0;
				default: m = -1;
			endcase
		end else begin
			m = $urandom_range(0, 65535);
		end
		return m[15:0];
	endfunction

	// Random command; sticks are mostly held across items while time advances.
	function automatic pad_cmd_t random_cmd();
		pad_cmd_t c;
		int       r;
		int       s;
		c = '0;
		c.ctrl = 2'($urandom_range(0, 3));
		c.any = 1'($urandom_range(0, 1));
		c.etype = ev_t'($urandom_range(0, 3));
		c.btn = 8'($urandom_range(0, 255));
		c.val = 8'($urandom_range(0, 255));
		c.sx = pick_axis();
		c.sy = pick_axis();
		r = $urandom_range(0, 19);
		if (r == 0) begin
			clock_ms = $urandom;
		end else if (r == 1) begin
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 120);
		end
		c.now = clock_ms;
		r = $urandom_range(0, 99);
		if (r < 58) begin
			c.op = OP_QUEUE;
		end else if (r < 90) begin
			c.op = OP_GET;
		end else if (r < 96) begin
			c.op = OP_FLUSH;
		end else begin
			c.op = OP_INIT;
		end
		if (c.etype == EV_LSTICK || c.etype == EV_RSTICK) begin
			s = (c.etype == EV_LSTICK) ? 0 : 1;
			if ($urandom_range(0, 2) != 0) begin
				c.sx = held_x[s][c.ctrl];
				c.sy = held_y[s][c.ctrl];
				if ($urandom_range(0, 3) == 0) begin
					c.sx = 16'(c.sx + $urandom_range(0, 8) - 4);
				end
			end
			held_x[s][c.ctrl] = c.sx;
			held_y[s][c.ctrl] = c.sy;
		end
		return c;
	endfunction

	// Drives one item and waits until the block takes it.
	task automatic send_item(input pad_cmd_t c, input logic pinned, input pad_res_t res);
		pad_res_t r;
		@(negedge clk);
		operation <= c.op;
		controller <= c.ctrl;
		any_controller <= c.any;
		event_type <= c.etype;
		stick_x <= c.sx;
		stick_y <= c.sy;
		button_id <= c.btn;
		button_value <= c.val;
		time_ms <= c.now;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = predict_pad_result(c);
		pending_results.push_back(pinned ? res : r);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Stops sending until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SUPPRESSED: cfg_suppressed = v[0];
			REG_THRESHOLD:  cfg_threshold = v;
			REG_INTERVAL:   cfg_interval = v;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic supp, input logic [15:0] thr,
		input logic [15:0] interval);
		drain_results();
		write_reg(REG_SUPPRESSED, {15'd0, supp});
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_INTERVAL, interval);
	endtask

	// Random items in bursts with gaps, draining once halfway through.
	task automatic run_random(input int n);
		int i;
		int burst_left;
		burst_left = $urandom_range(1, 16);
		for (i = 0; i < n; i++) begin
			send_item(random_cmd(), 1'b0, '0);
			if (i == n / 2) begin
				drain_results();
			end
			burst_left--;
			if (burst_left == 0) begin
				if ($urandom_range(0, 9) < 3) begin
					idle_cycles(0);
				end else begin
					idle_cycles($urandom_range(1, 6));
				end
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// Result checker: each strobed result against the oldest expectation.
	always @(posedge clk) begin : check_results
		pad_res_t got;
		pad_res_t want;
		if (arst_n && done) begin
			got = {valid_res, out_type, out_controller, out_x, out_y, out_button,
				out_value, last_event_time};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result at %0t: valid=%0d type=%0d ctrl=%0d", $realtime,
						got.valid, got.etype, got.ctrl);
				end
			end else begin
				want = pending_results.pop_front();
				if (got.valid !== want.valid || got.etype !== want.etype ||
					got.ctrl !== want.ctrl || got.x !== want.x || got.y !== want.y ||
					got.btn !== want.btn || got.val !== want.val ||
					got.let_ms !== want.let_ms) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected valid=%0d type=%0d ctrl=%0d x=%0d y=%0d btn=%0d val=%0d last=%0d",
							want.valid, want.etype, want.ctrl, $signed(want.x), $signed(want.y),
							want.btn, want.val, want.let_ms);
						$display("  actual   valid=%0d type=%0d ctrl=%0d x=%0d y=%0d btn=%0d val=%0d last=%0d",
							got.valid, got.etype, got.ctrl, $signed(got.x), $signed(got.y),
							got.btn, got.val, got.let_ms);
					end
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : main_sequence
		int i;
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_QUEUE;
		controller = 2'd0;
		any_controller = 1'b0;
		event_type = EV_NULL;
		stick_x = '0;
		stick_y = '0;
		button_id = '0;
		button_value = '0;
		time_ms = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_SUPPRESSED;
		cfg_wdata = '0;
		mismatch_count = 0;
		cycle_count = 0;
		clock_ms = 32'd1000;

		// Shadow state matches the block's state after reset.
		for (k = 0; k < CONTROLLERS; k++) begin
			for (i = 0; i < QUEUE_DEPTH; i++) begin
				queue_mem[k][i] = '0;
			end
		end
		for (k = 0; k < 2; k++) begin
			for (i = 0; i < CONTROLLERS; i++) begin
				prev_x[k][i] = '0;
				prev_y[k][i] = '0;
				stick_post_ms[k][i] = '0;
			end
			for (i = 0; i < 4; i++) begin
				held_x[k][i] = '0;
				held_y[k][i] = '0;
			end
		end
		last_post_ms = '0;
		cfg_suppressed = 1'b0;
		cfg_threshold = THRESH_RST;
		cfg_interval = INTERVAL_RST;

		// Directed rows: empty get, button extremes, null, stick crossing,
		// held stick inside and past the interval, exact threshold, time wrap,
		// per-controller and scanning gets, flush and initialize.
		add_row(OP_GET, 2'd0, 1'b1, EV_NULL, 0, 0, 0, 0, 32'd5);
		pin_result(1'b0, EV_NULL, 2'd0, 8'd0, 8'd0, 32'd0);
		add_row(OP_QUEUE, 2'd0, 1'b0, EV_BUTTON, 0, 0, 0, 0, 32'd10);
		pin_result(1'b1, EV_BUTTON, 2'd0, 8'd0, 8'd0, 32'd10);
		add_row(OP_QUEUE, 2'd3, 1'b0, EV_BUTTON, 0, 0, 255, 255, 32'd20);
		pin_result(1'b1, EV_BUTTON, 2'd3, 8'd255, 8'd255, 32'd20);
		add_row(OP_QUEUE, 2'd1, 1'b0, EV_NULL, 0, 0, 0, 0, 32'd30);
		pin_result(1'b1, EV_NULL, 2'd1, 8'd0, 8'd0, 32'd20);
		add_row(OP_QUEUE, 2'd0, 1'b0, EV_LSTICK, 32767, 0, 0, 0, 32'd40);
		add_row(OP_QUEUE, 2'd0, 1'b0, EV_LSTICK, -32768, -32768, 0, 0, 32'd100);
		add_row(OP_QUEUE, 2'd0, 1'b0, EV_LSTICK, -30000, -30000, 0, 0, 32'd200);
		add_row(OP_QUEUE, 2'd0, 1'b0, EV_LSTICK, -30000, -30000, 0, 0, 32'd350);
		add_row(OP_QUEUE, 2'd2, 1'b0, EV_RSTICK, 100, -100, 0, 0, 32'd400);
		add_row(OP_QUEUE, 2'd2, 1'b0, EV_RSTICK, 29490, -29490, 0, 0, 32'hFFFF_FFFF);
		add_row(OP_QUEUE, 2'd2, 1'b0, EV_RSTICK, -29490, 29490, 0, 0, 32'd5);
		add_row(OP_QUEUE, 2'd2, 1'b0, EV_RSTICK, -29490, 29490, 0, 0, 32'd300);
		add_row(OP_GET, 2'd0, 1'b0, EV_NULL, 0, 0, 0, 0, 32'd310);
		add_row(OP_GET, 2'd0, 1'b1, EV_NULL, 0, 0, 0, 0, 32'd320);
		add_row(OP_GET, 2'd1, 1'b0, EV_NULL, 0, 0, 0, 0, 32'd330);
		add_row(OP_GET, 2'd3, 1'b0, EV_NULL, 0, 0, 0, 0, 32'd340);
		add_row(OP_GET, 2'd2, 1'b1, EV_NULL, 0, 0, 0, 0, 32'd350);
		add_row(OP_FLUSH, 2'd0, 1'b0, EV_NULL, 0, 0, 0, 0, 32'd360);
		add_row(OP_GET, 2'd0, 1'b1, EV_NULL, 0, 0, 0, 0, 32'd370);
		add_row(OP_INIT, 2'd0, 1'b0, EV_NULL, 0, 0, 0, 0, 32'hDEAD_BEEF);
		pin_result(1'b0, EV_NULL, 2'd0, 8'd0, 8'd0, 32'hDEAD_BEEF);
		add_row(OP_GET, 2'd0, 1'b1, EV_NULL, 0, 0, 0, 0, 32'd380);
		pin_result(1'b0, EV_NULL, 2'd0, 8'd0, 8'd0, 32'hDEAD_BEEF);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < directed_rows.size(); i++) begin
			send_item(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].res);
		end

		// Random phases across the configuration space, extremes included.
		run_random(300);
		set_config(1'b0, 16'd0, 16'd0);
		run_random(150);
		set_config(1'b0, 16'h8000, 16'hFFFF);
		run_random(150);
		set_config(1'b1, 16'd1000, 16'd100);
		run_random(100);
		set_config(1'b0, 16'($urandom_range(0, 32768)), 16'($urandom_range(0, 600)));
		run_random(200);
		set_config(1'b0, THRESH_RST, INTERVAL_RST);
		run_random(250);

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* gamepad_event_queue_autorepeat.f */
+incdir+rtl/core
rtl/core/geq_pkg.sv
rtl/core/geq_ram.sv
rtl/core/geq_stick.sv
rtl/core/geq_queue.sv
rtl/core/gamepad_event_queue_autorepeat.sv
bench/gamepad_event_queue_autorepeat_tb.sv
